@@ src/ctc_pkg.sv @@
// Package for the calendar time counter: opcodes, beat structs, calendar constants
// and the month length table. Used by ctc_in_stage, ctc_core and the top level.
package ctc_pkg;

    // Year counter width as kept in four-digit mode (valid range 7 to 16).
    localparam int YEAR_WIDTH = 16;
    localparam logic [15:0] YEAR_MASK =
        (YEAR_WIDTH >= 16) ? 16'hFFFF : 16'((64'd1 << YEAR_WIDTH) - 64'd1);

    // Calendar limits.
    localparam logic [5:0] SEC_LAST    = 6'd59;
    localparam logic [5:0] MIN_LAST    = 6'd59;
    localparam logic [5:0] ROUND_SEC   = 6'd30;
    localparam logic [5:0] HOURS       = 6'd24;
    localparam logic [2:0] WDAY_LAST   = 3'd7;
    localparam logic [4:0] MONTH_WRAP  = 5'd13;
    localparam logic [16:0] YEAR_WRAP2 = 17'd100;
    localparam logic [7:0] CENTURY     = 8'd100;

    // Reciprocal of 100 scaled by 2^19, rounded down; the quotient is then low by at most one.
    localparam logic [12:0] RECIP_100  = 13'd5242;
    localparam int          RECIP_SHIFT = 19;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ADJUST = 2'd1,
        OP_SET    = 2'd2,
        OP_REPORT = 2'd3
    } op_t;

    // Command as held in the input register, with the year quotient precomputed.
    typedef struct packed {
        op_t         opcode;
        logic        report_after_set;
        logic [15:0] set_year;
        logic [9:0]  year_quot;
        logic [3:0]  set_month;
        logic [4:0]  set_day;
        logic [2:0]  set_weekday;
        logic [4:0]  set_hour;
        logic [5:0]  set_minute;
        logic [5:0]  set_second;
    } cmd_t;

    // Full calendar time.
    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [2:0]  weekday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_t;

    // Days in a month; months outside 1 to 12 count as 31 days. February is always 28.
    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] len;
        begin
            case (month)
                4'd2:    len = 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

@@ src/ctc_if.sv @@
// Valid/ready channel interfaces of the calendar time counter: command in, time out.
// Standalone; no package needed.
interface ctc_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic        report_after_set;
    logic [15:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [2:0]  set_weekday;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;

    modport source (
        output valid, opcode, report_after_set, set_year, set_month, set_day,
               set_weekday, set_hour, set_minute, set_second,
        input  ready
    );
    modport sink (
        input  valid, opcode, report_after_set, set_year, set_month, set_day,
               set_weekday, set_hour, set_minute, set_second,
        output ready
    );
endinterface

interface ctc_time_if;
    logic        valid;
    logic        ready;
    logic [15:0] year_now;
    logic [3:0]  month_now;
    logic [4:0]  day_now;
    logic [2:0]  weekday_now;
    logic [4:0]  hour_now;
    logic [5:0]  minute_now;
    logic [5:0]  second_now;

    modport source (
        output valid, year_now, month_now, day_now, weekday_now, hour_now,
               minute_now, second_now,
        input  ready
    );
    modport sink (
        input  valid, year_now, month_now, day_now, weekday_now, hour_now,
               minute_now, second_now,
        output ready
    );
endinterface

@@ src/ctc_in_stage.sv @@
// Input register of the calendar time counter. Captures one command beat and
// precomputes the year quotient by 100. Depends on ctc_pkg and ctc_if.
module ctc_in_stage
    import ctc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ctc_cmd_if.sink      cmd,
    input  logic         take,
    output logic         hold_valid,
    output cmd_t         hold_cmd
);

    logic        valid_reg;
    logic        valid_next;
    cmd_t        cmd_reg;
    cmd_t        cmd_next;
    logic [28:0] quot_prod;
    logic        accept;

    // The register frees up in the same cycle its beat moves on.
    assign cmd.ready = !valid_reg || take;
    assign accept    = cmd.valid && cmd.ready;

    // Year times the scaled reciprocal; the top bits are floor(year / 100) or one less.
    assign quot_prod = 29'(cmd.set_year) * 29'(RECIP_100);

    always_comb
    begin
        cmd_next                  = cmd_reg;
        valid_next                = valid_reg;
        if (take)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next                = 1'b1;
            cmd_next.opcode           = op_t'(cmd.opcode);
            cmd_next.report_after_set = cmd.report_after_set;
            cmd_next.set_year         = cmd.set_year;
            cmd_next.year_quot        = quot_prod[RECIP_SHIFT +: 10];
            cmd_next.set_month        = cmd.set_month;
            cmd_next.set_day          = cmd.set_day;
            cmd_next.set_weekday      = cmd.set_weekday;
            cmd_next.set_hour         = cmd.set_hour;
            cmd_next.set_minute       = cmd.set_minute;
            cmd_next.set_second       = cmd.set_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign hold_valid = valid_reg;
    assign hold_cmd   = cmd_reg;

`ifndef SYNTHESIS
    // A held command that is not taken stays in the register.
    a_hold_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !take |=> valid_reg && $stable(cmd_reg))
        else $error("input register dropped a command");
`endif

endmodule

@@ src/ctc_core.sv @@
// Calendar state and its combinational next-state update, plus the result register.
// Depends on ctc_pkg and ctc_if.
module ctc_core
    import ctc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         four_digit,
    input  logic         hold_valid,
    input  cmd_t         hold_cmd,
    output logic         take,
    ctc_time_if.source   rpt
);

    cal_t        time_reg;
    cal_t        time_next;
    cal_t        out_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        emit;

    logic        min_step;
    logic        day_step;
    logic        hour_inc;
    logic [5:0]  hour_sum;
    logic [5:0]  day_sum;
    logic [4:0]  month_sum;
    logic [16:0] year_sum;
    logic [15:0] year_rem16;
    logic [7:0]  year_rem;
    logic [15:0] set_year_val;

    // A command moves on whenever the result register is free or being emptied.
    assign take = hold_valid && (!out_valid_reg || rpt.ready);
    assign emit = take && ((hold_cmd.opcode != OP_SET) || hold_cmd.report_after_set);

    // Year modulo 100 from the precomputed quotient, with one correction step.
    assign year_rem16 = hold_cmd.set_year - ({6'd0, hold_cmd.year_quot} << 6)
                        - ({6'd0, hold_cmd.year_quot} << 5)
                        - ({6'd0, hold_cmd.year_quot} << 2);
    assign year_rem   = (year_rem16[7:0] >= CENTURY) ? year_rem16[7:0] - CENTURY
                                                     : year_rem16[7:0];
    assign set_year_val = four_digit ? (hold_cmd.set_year & YEAR_MASK) : {8'd0, year_rem};

    // Next calendar state: seconds, then minute/hour carry, then day/month/year carry.
    always_comb
    begin
        time_next = time_reg;
        min_step  = 1'b0;
        day_step  = 1'b0;
        hour_inc  = 1'b0;
        hour_sum  = 6'd0;
        day_sum   = 6'd0;
        month_sum = 5'd0;
        year_sum  = 17'd0;

        case (hold_cmd.opcode)
            OP_TICK:
            begin
                if (time_reg.second >= SEC_LAST)
                begin
                    time_next.second = 6'd0;
                    min_step         = 1'b1;
                end
                else
                begin
                    time_next.second = time_reg.second + 6'd1;
                end
            end
            OP_ADJUST:
            begin
                time_next.second = 6'd0;
                min_step         = (time_reg.second >= ROUND_SEC);
            end
            OP_SET:
            begin
                time_next.year    = set_year_val;
                time_next.month   = hold_cmd.set_month;
                time_next.day     = hold_cmd.set_day;
                time_next.weekday = hold_cmd.set_weekday;
                time_next.hour    = hold_cmd.set_hour;
                time_next.minute  = hold_cmd.set_minute;
                time_next.second  = hold_cmd.set_second;
            end
            default:
            begin
                time_next = time_reg;
            end
        endcase

        // Minute advance; an hour of 24 or more rolls over even without a carry.
        if (min_step)
        begin
            if (time_reg.minute >= MIN_LAST)
            begin
                time_next.minute = 6'd0;
                hour_inc         = 1'b1;
            end
            else
            begin
                time_next.minute = time_reg.minute + 6'd1;
            end
            hour_sum = {1'b0, time_reg.hour} + {5'd0, hour_inc};
            if (hour_sum >= HOURS)
            begin
                time_next.hour = 5'd0;
                day_step       = 1'b1;
            end
            else
            begin
                time_next.hour = hour_sum[4:0];
            end
        end

        // Day advance with weekday, month and year carries.
        if (day_step)
        begin
            time_next.weekday = (time_reg.weekday >= WDAY_LAST) ? 3'd1
                                                                : time_reg.weekday + 3'd1;
            day_sum   = {1'b0, time_reg.day} + 6'd1;
            month_sum = {1'b0, time_reg.month};
            if (day_sum > {1'b0, month_days(time_reg.month)})
            begin
                day_sum   = 6'd1;
                month_sum = month_sum + 5'd1;
            end
            if (month_sum >= MONTH_WRAP)
            begin
                month_sum = 5'd1;
                year_sum  = {1'b0, time_reg.year} + 17'd1;
                if (four_digit)
                begin
                    time_next.year = year_sum[15:0] & YEAR_MASK;
                end
                else
                begin
                    time_next.year = (year_sum >= YEAR_WRAP2) ? 16'd0 : year_sum[15:0];
                end
            end
            time_next.day   = day_sum[4:0];
            time_next.month = month_sum[3:0];
        end
    end

    // Result register valid flag.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rpt.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Calendar state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg.year    <= 16'd0;
            time_reg.month   <= 4'd1;
            time_reg.day     <= 5'd1;
            time_reg.weekday <= 3'd1;
            time_reg.hour    <= 5'd0;
            time_reg.minute  <= 6'd0;
            time_reg.second  <= 6'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                time_reg <= time_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= time_next;
        end
    end

    assign rpt.valid       = out_valid_reg;
    assign rpt.year_now    = out_reg.year;
    assign rpt.month_now   = out_reg.month;
    assign rpt.day_now     = out_reg.day;
    assign rpt.weekday_now = out_reg.weekday;
    assign rpt.hour_now    = out_reg.hour;
    assign rpt.minute_now  = out_reg.minute;
    assign rpt.second_now  = out_reg.second;

`ifndef SYNTHESIS
    // Every command other than a set produces a result beat.
    a_emit_on_report: assert property (@(posedge clk) disable iff (!rst_n)
        take && (hold_cmd.opcode != OP_SET) |=> out_valid_reg)
        else $error("command finished without a result");

    // An adjust always leaves the seconds at zero.
    a_adjust_clears_sec: assert property (@(posedge clk) disable iff (!rst_n)
        take && (hold_cmd.opcode == OP_ADJUST) |=> time_reg.second == 6'd0)
        else $error("adjust left seconds nonzero");

    // A set in two-digit mode stores a year below 100.
    a_set_two_digit: assert property (@(posedge clk) disable iff (!rst_n)
        take && (hold_cmd.opcode == OP_SET) && !four_digit |=> time_reg.year < 16'd100)
        else $error("two-digit year out of range after set");

    // The result payload follows the state it was taken from.
    a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_reg == time_reg)
        else $error("result differs from the calendar state");
`endif

endmodule

@@ src/calendar_time_counter_top.sv @@
// Top level of the calendar time counter: configuration register and the two stages.
// Depends on ctc_pkg, ctc_if, ctc_in_stage and ctc_core.
//
// The block keeps a calendar time (second, minute, hour, day, weekday 1 to 7,
// month 1 to 12, year) and takes one command beat per cycle: tick one second,
// adjust to the nearest minute, set all fields, or report. Tick, adjust and report
// return the time after the command as one result beat; a set returns one only when
// report_after_set is high. From acceptance a command passes through the input
// register, where the carry chain of the calendar counters settles, and then the
// result register. The carry chain is combinational, so one command per cycle is taken
// while results are not stalled; a stalled result holds back the input register.
// February always has 28 days. The year wraps at 100 unless four_digit_reg is set,
// in which case it wraps at 16 bits. Write cfg_wdata with cfg_we only while idle.
module calendar_time_counter_top
    import ctc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_wdata,
    ctc_cmd_if.sink      cmd,
    ctc_time_if.source   rpt
);

    logic four_digit_reg;
    logic hold_valid;
    cmd_t hold_cmd;
    logic take;

    // Year mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_digit_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            four_digit_reg <= cfg_wdata;
        end
    end

    ctc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .take       (take),
        .hold_valid (hold_valid),
        .hold_cmd   (hold_cmd)
    );

    ctc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .four_digit (four_digit_reg),
        .hold_valid (hold_valid),
        .hold_cmd   (hold_cmd),
        .take       (take),
        .rpt        (rpt)
    );

endmodule
